### rtl/core/cdas_pkg.sv
// Package: shared types, opcode and condition codes, decode helpers.
package cdas_pkg;

    localparam logic [15:0] LOGIC_OPS = 16'hf303;
    localparam logic [15:0] WRITES_RD = 16'hf0ff;
    localparam logic [31:0] MASK32    = 32'hffffffff;

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_SBC = 4'd6;
    localparam logic [3:0] OP_RSC = 4'd7;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_BIC = 4'd14;
    localparam logic [3:0] OP_MVN = 4'd15;

    localparam logic [3:0] CC_EQ = 4'd0;
    localparam logic [3:0] CC_NE = 4'd1;
    localparam logic [3:0] CC_CS = 4'd2;
    localparam logic [3:0] CC_CC = 4'd3;
    localparam logic [3:0] CC_MI = 4'd4;
    localparam logic [3:0] CC_PL = 4'd5;
    localparam logic [3:0] CC_VS = 4'd6;
    localparam logic [3:0] CC_VC = 4'd7;
    localparam logic [3:0] CC_HI = 4'd8;
    localparam logic [3:0] CC_LS = 4'd9;
    localparam logic [3:0] CC_GE = 4'd10;
    localparam logic [3:0] CC_LT = 4'd11;
    localparam logic [3:0] CC_GT = 4'd12;
    localparam logic [3:0] CC_LE = 4'd13;
    localparam logic [3:0] CC_AL = 4'd14;
    localparam logic [3:0] CC_NV = 4'd15;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [3:0]  cond;
        logic [3:0]  opcode;
        logic        set_flags;
        logic        imm_form;
        logic [11:0] operand2_field;
        logic [31:0] first_operand;
        logic [31:0] shifted_value;
        logic [7:0]  shift_by_reg;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result;
        logic        write_dest;
        logic        executed;
        logic [3:0]  flags_out;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic [3:0]  cond;
        logic [3:0]  opcode;
        logic        upd_flags;
        logic        is_logic;
        logic        writes_rd;
        logic        imm_form;
        logic [11:0] operand2_field;
        logic [31:0] first_operand;
        logic [31:0] shifted_value;
        logic [7:0]  shift_by_reg;
    } t_dec_item;

endpackage

### rtl/core/cdas_front.sv
// Front end: accept items, classify opcode, hand off to the queue.
module cdas_front import cdas_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_dec_item o_dec
);
    logic      r_valid;
    t_dec_item r_dec;
    t_dec_item n_dec;
    logic      w_take;

    assign o_full  = r_valid && !i_ready;
    assign w_take  = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_dec   = r_dec;

    always_comb begin
        n_dec.cond           = i_item.cond;
        n_dec.opcode         = i_item.opcode;
        n_dec.upd_flags      = i_item.set_flags || (i_item.opcode[3:2] == 2'b10);
        n_dec.is_logic       = LOGIC_OPS[i_item.opcode];
        n_dec.writes_rd      = WRITES_RD[i_item.opcode];
        n_dec.imm_form       = i_item.imm_form;
        n_dec.operand2_field = i_item.operand2_field;
        n_dec.first_operand  = i_item.first_operand;
        n_dec.shifted_value  = i_item.shifted_value;
        n_dec.shift_by_reg   = i_item.shift_by_reg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_dec <= n_dec;
        end
    end
endmodule

### rtl/core/cdas_queue.sv
// Short queue between front and back ends.
module cdas_queue import cdas_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_dec_item i_dec,
    output logic      o_valid,
    input  logic      i_ready,
    output t_dec_item o_dec
);
    t_dec_item r_mem [QDEPTH];
    logic      r_wp;
    logic      r_rp;
    logic [1:0] r_cnt;
    logic      w_wr;
    logic      w_rd;

    assign o_ready = (r_cnt != 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_dec   = r_mem[r_rp];
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_dec;
        end
    end
endmodule

### rtl/core/cdas_back.sv
// Back end: condition test, barrel shifter, ALU, flag register, result register.
module cdas_back import cdas_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_dec_item i_dec,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);
    logic [3:0]  r_nzcv;
    logic        r_full;
    t_out_item   r_out;
    t_out_item   n_out;
    logic [3:0]  n_nzcv;
    logic        w_take;
    logic        w_n, w_z, w_c, w_v, w_pass;
    logic [31:0] w_b, w_a, w_rm, w_r, w_sa, w_sb;
    logic        w_sc, w_cin;
    logic [32:0] w_sum;
    logic [1:0]  w_type;
    logic [4:0]  w_amt5;
    logic [7:0]  w_amt;
    logic [4:0]  w_rot;
    logic [63:0] w_dbl;
    logic [31:0] w_imm;

    assign o_empty = !r_full;
    assign o_ready = !r_full || i_pop;
    assign w_take  = i_valid && o_ready;
    assign o_item  = r_out;

    assign w_n = r_nzcv[3];
    assign w_z = r_nzcv[2];
    assign w_c = r_nzcv[1];
    assign w_v = r_nzcv[0];

    always_comb begin
        case (i_dec.cond)
            CC_EQ:   w_pass = w_z;
            CC_NE:   w_pass = !w_z;
            CC_CS:   w_pass = w_c;
            CC_CC:   w_pass = !w_c;
            CC_MI:   w_pass = w_n;
            CC_PL:   w_pass = !w_n;
            CC_VS:   w_pass = w_v;
            CC_VC:   w_pass = !w_v;
            CC_HI:   w_pass = w_c && !w_z;
            CC_LS:   w_pass = !w_c || w_z;
            CC_GE:   w_pass = (w_n == w_v);
            CC_LT:   w_pass = (w_n != w_v);
            CC_GT:   w_pass = !w_z && (w_n == w_v);
            CC_LE:   w_pass = w_z || (w_n != w_v);
            CC_AL:   w_pass = 1'b1;
            default: w_pass = 1'b0;
        endcase
    end

    always_comb begin
        w_rm   = i_dec.shifted_value;
        w_type = i_dec.operand2_field[6:5];
        w_rot  = {i_dec.operand2_field[11:8], 1'b0};
        w_dbl  = {24'd0, i_dec.operand2_field[7:0], 24'd0, i_dec.operand2_field[7:0]} >> w_rot;
        w_imm  = w_dbl[31:0];
        w_b    = w_rm;
        w_sc   = w_c;
        w_amt  = i_dec.shift_by_reg;
        w_amt5 = i_dec.operand2_field[11:7];
        if (i_dec.imm_form) begin
            w_b  = w_imm;
            w_sc = (w_rot != 5'd0) ? w_imm[31] : w_c;
        end else if (i_dec.operand2_field[4]) begin
            w_amt5 = w_amt[4:0];
            if (w_amt == 8'd0) begin
                w_b  = w_rm;
                w_sc = w_c;
            end else if (w_type == SH_LSL) begin
                if (w_amt < 8'd32) begin
                    w_b  = w_rm << w_amt5;
                    w_sc = w_rm[5'd0 - w_amt5];
                end else begin
                    w_b  = 32'd0;
                    w_sc = (w_amt == 8'd32) && w_rm[0];
                end
            end else if (w_type == SH_LSR) begin
                if (w_amt < 8'd32) begin
                    w_b  = w_rm >> w_amt5;
                    w_sc = w_rm[w_amt5 - 5'd1];
                end else begin
                    w_b  = 32'd0;
                    w_sc = (w_amt == 8'd32) && w_rm[31];
                end
            end else if (w_type == SH_ASR) begin
                if (w_amt < 8'd32) begin
                    w_b  = 32'($signed(w_rm) >>> w_amt5);
                    w_sc = w_rm[w_amt5 - 5'd1];
                end else begin
                    w_b  = {32{w_rm[31]}};
                    w_sc = w_rm[31];
                end
            end else begin
                if (w_amt5 == 5'd0) begin
                    w_b  = w_rm;
                    w_sc = w_rm[31];
                end else begin
                    w_dbl = {w_rm, w_rm} >> w_amt5;
                    w_b   = w_dbl[31:0];
                    w_sc  = w_rm[w_amt5 - 5'd1];
                end
            end
        end else begin
            if (w_type == SH_LSL) begin
                if (w_amt5 != 5'd0) begin
                    w_b  = w_rm << w_amt5;
                    w_sc = w_rm[5'd0 - w_amt5];
                end
            end else if (w_type == SH_LSR) begin
                w_b  = (w_amt5 == 5'd0) ? 32'd0 : (w_rm >> w_amt5);
                w_sc = (w_amt5 == 5'd0) ? w_rm[31] : w_rm[w_amt5 - 5'd1];
            end else if (w_type == SH_ASR) begin
                w_b  = (w_amt5 == 5'd0) ? {32{w_rm[31]}}
                                        : 32'($signed(w_rm) >>> w_amt5);
                w_sc = (w_amt5 == 5'd0) ? w_rm[31] : w_rm[w_amt5 - 5'd1];
            end else begin
                if (w_amt5 == 5'd0) begin
                    w_b  = {w_c, w_rm[31:1]};
                    w_sc = w_rm[0];
                end else begin
                    w_dbl = {w_rm, w_rm} >> w_amt5;
                    w_b   = w_dbl[31:0];
                    w_sc  = w_rm[w_amt5 - 5'd1];
                end
            end
        end
    end

    always_comb begin
        w_a   = i_dec.first_operand;
        w_sa  = w_a;
        w_sb  = w_b;
        w_cin = 1'b0;
        case (i_dec.opcode)
            OP_SUB, OP_CMP: begin w_sb = ~w_b; w_cin = 1'b1; end
            OP_RSB:         begin w_sa = w_b; w_sb = ~w_a; w_cin = 1'b1; end
            OP_ADC:         begin w_cin = w_c; end
            OP_SBC:         begin w_sb = ~w_b; w_cin = w_c; end
            OP_RSC:         begin w_sa = w_b; w_sb = ~w_a; w_cin = w_c; end
            default:        begin w_cin = 1'b0; end
        endcase
        w_sum = {1'b0, w_sa} + {1'b0, w_sb} + {32'd0, w_cin};
        case (i_dec.opcode)
            OP_AND, OP_TST: w_r = w_a & w_b;
            OP_EOR, OP_TEQ: w_r = w_a ^ w_b;
            OP_ORR:         w_r = w_a | w_b;
            OP_MOV:         w_r = w_b;
            OP_BIC:         w_r = w_a & ~w_b;
            OP_MVN:         w_r = ~w_b;
            default:        w_r = w_sum[31:0];
        endcase
    end

    always_comb begin
        n_nzcv = r_nzcv;
        if (w_pass && i_dec.upd_flags) begin
            n_nzcv[3] = w_r[31];
            n_nzcv[2] = (w_r == 32'd0);
            if (i_dec.is_logic) begin
                n_nzcv[1] = w_sc;
            end else begin
                n_nzcv[1] = w_sum[32];
                n_nzcv[0] = (w_sa[31] ^ w_r[31]) & (w_sb[31] ^ w_r[31]);
            end
        end
        n_out.result     = w_pass ? (w_r & MASK32) : 32'd0;
        n_out.write_dest = w_pass && i_dec.writes_rd;
        n_out.executed   = w_pass;
        n_out.flags_out  = n_nzcv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nzcv <= 4'd0;
            r_full <= 1'b0;
        end else begin
            if (w_take) begin
                r_nzcv <= n_nzcv;
                r_full <= 1'b1;
            end else if (i_pop) begin
                r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end
endmodule

### rtl/core/cond_dataproc_alu_shifter.sv
// Top level: conditional data-processing ALU with barrel shifter.
// Takes one data-processing instruction per cycle, while full is low, through a
// queue-style port (push/full in, pop/empty out). A front register classifies the
// opcode, a two-entry queue decouples it from the back end, and the back end tests
// the condition, shifts operand 2, runs the ALU and updates NZCV in the cycle it
// takes the item, so the flags reach the next instruction directly. A result passes
// the front register, a queue entry and the result register in turn; sustained rate
// is one item per cycle while pop keeps up. Up to four items can wait (front
// register, two queue entries, result register) before full rises.
module cond_dataproc_alu_shifter import cdas_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);
    logic      w_fv, w_fr, w_qv, w_qr;
    t_dec_item w_fd, w_qd;

    cdas_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(i_item), .o_valid(w_fv), .i_ready(w_fr), .o_dec(w_fd)
    );

    cdas_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .o_ready(w_fr),
        .i_dec(w_fd), .o_valid(w_qv), .i_ready(w_qr), .o_dec(w_qd)
    );

    cdas_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_ready(w_qr),
        .i_dec(w_qd), .o_empty(empty), .i_pop(pop), .o_item(o_item)
    );
endmodule
